### hw/rtl/decimal_display_formatter_top_defines.svh
// ---------------------------------------------------------------------------
// decimal_display_formatter_top_defines
// Assertion macros shared by the display formatter modules.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_DISPLAY_FORMATTER_TOP_DEFINES_SVH
`define DECIMAL_DISPLAY_FORMATTER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define DDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/ddf_pkg.sv
// ---------------------------------------------------------------------------
// ddf_pkg
// Types and fixed constants of the decimal display formatter.
// ---------------------------------------------------------------------------
package ddf_pkg;

   // driver register codes
   localparam logic [3:0] SCAN_LIMIT_ADDR = 4'd11;
   localparam logic [7:0] BLANK_CODE      = 8'd15;
   localparam logic [7:0] POINT_BIT       = 8'h80;

   // divide by ten: (x * 52429) >> 19 is exact for any 16-bit x
   localparam logic [32:0] RECIP_TEN   = 33'd52429;
   localparam int          RECIP_SHIFT = 19;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // classified item as held in the queue
   typedef struct packed {
      logic        kind;
      logic [15:0] value;
      logic        point_hi;
      logic        point_lo;
   } entry_type;

   // queue push side
   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

### hw/rtl/ddf_channels.sv
// ---------------------------------------------------------------------------
// ddf channels
// Valid/ready interfaces for the request and the register-write items.
// ---------------------------------------------------------------------------
interface ddf_req_if;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [15:0]       value;
   logic signed [7:0] point_value;
   logic [7:0]        point_type;

   modport source (output valid, output kind, output value, output point_value,
                   output point_type, input ready);
   modport sink   (input valid, input kind, input value, input point_value,
                   input point_type, output ready);
endinterface

interface ddf_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] reg_addr;
   logic [7:0] reg_data;
   logic       last;

   modport source (output valid, output reg_addr, output reg_data, output last,
                   input ready);
   modport sink   (input valid, input reg_addr, input reg_data, input last,
                   output ready);
endinterface

### hw/rtl/decimal_display_formatter_top.sv
// ---------------------------------------------------------------------------
// decimal_display_formatter_top
// Formats a 16-bit value into register writes for a code-B display driver.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one item: kind, value, point_value, point_type.
//   rsp_chan carries the register writes it causes: first the scan limit
//   (address 11, data DIGIT_COUNT-1), then one write per digit position,
//   least significant digit first, positions DIGIT_COUNT down to 1;
//   last is high on the final write of each item.
//   For an item accepted into an empty block, the scan limit write passes
//   through the queue and then the output register; the digit writes
//   follow one per cycle while the receiver is ready. Each item makes
//   DIGIT_COUNT+1 writes through the single output register, which the
//   digit sequencer feeds one write per cycle unless the receiver stalls.
//   A two-item queue between the front end and the sequencer lets
//   requests be taken while writes are still going out.
//   When the receiver stalls, the output register holds its write and the
//   sequencer waits; requests are still taken until the queue is full.
//   Synchronous reset empties the queue and the output register; no
//   other state survives between items.
// ---------------------------------------------------------------------------
module decimal_display_formatter_top #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic      clock,
   input  logic      reset,
   ddf_req_if.sink   req_chan,
   ddf_rsp_if.source rsp_chan
);
   import ddf_pkg::*;

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   // front end: accept and classify
   ddf_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_out   (push)
   );

   // queue between front and back
   ddf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .full    (queue_full),
      .head    (head)
   );

   // back end: write sequencer
   ddf_back #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### hw/rtl/ddf_front.sv
// ---------------------------------------------------------------------------
// ddf_front
// Accepts request items and reduces the point inputs to two flags.
// ---------------------------------------------------------------------------
module ddf_front (
   ddf_req_if.sink         req_chan,
   input  logic            queue_full,
   output ddf_pkg::push_type push_out
);
   import ddf_pkg::*;

   // accept whenever the queue has room
   assign req_chan.ready = !queue_full;

   // classify: point flags only matter in point mode
   always_comb begin
      push_out.push           = req_chan.valid && !queue_full;
      push_out.entry.kind     = req_chan.kind;
      push_out.entry.value    = req_chan.value;
      push_out.entry.point_hi = req_chan.kind && (req_chan.point_value > 8'sd0);
      push_out.entry.point_lo = req_chan.kind && (req_chan.point_type == 8'd1);
   end

endmodule

### hw/rtl/ddf_queue.sv
// ---------------------------------------------------------------------------
// ddf_queue
// Short first-in first-out queue between front and back end.
// ---------------------------------------------------------------------------
`include "decimal_display_formatter_top_defines.svh"

module ddf_queue (
   input  logic              clock,
   input  logic              reset,
   input  ddf_pkg::push_type push_in,
   input  logic              pop,
   output logic              full,
   output ddf_pkg::head_type head
);
   import ddf_pkg::*;

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_pop;

   assign full       = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_in.push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_in.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_in.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_in.push) begin
         slot_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

   `DDF_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, count_ff <= (QPTR_W + 1)'(QUEUE_DEPTH), "queue fill count beyond depth")
   `DDF_ASSERT_NOW(a_queue_no_overflow, clock, reset, full, !push_in.push, "push into a full queue")
   `DDF_ASSERT_NEXT(a_queue_fill, clock, reset, push_in.push && !do_pop, count_ff == $past(count_ff) + 1'b1, "fill count missed a push")

endmodule

### hw/rtl/ddf_back.sv
// ---------------------------------------------------------------------------
// ddf_back
// Sequencer that turns one queued item into scan-limit and digit writes.
// ---------------------------------------------------------------------------
`include "decimal_display_formatter_top_defines.svh"

module ddf_back #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  ddf_pkg::head_type head,
   output logic              pop,
   ddf_rsp_if.source         rsp_chan
);
   import ddf_pkg::*;

   localparam int STEP_W = $clog2(DIGIT_COUNT + 1);

   // sequencer state
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [15:0]       rest_ff, rest_in;
   logic              kind_ff, kind_in;
   logic              point_hi_ff, point_hi_in;
   logic              point_lo_ff, point_lo_in;

   // output register
   logic              out_valid_ff, out_valid_in;
   logic [3:0]        out_addr_ff, out_addr_in;
   logic [7:0]        out_data_ff, out_data_in;
   logic              out_last_ff, out_last_in;

   logic              advance;
   logic [32:0]       product;
   logic [15:0]       quot;
   logic [15:0]       rem_wide;
   logic [3:0]        position;
   logic              shown;
   logic [7:0]        digit_data;

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign pop     = advance && !busy_ff && head.valid;

   // one decimal digit: quotient by reciprocal, remainder by shift-add
   always_comb begin
      product    = {17'd0, rest_ff} * RECIP_TEN;
      quot       = product[RECIP_SHIFT +: 16];
      rem_wide   = rest_ff - ((quot << 3) + (quot << 1));
      position   = 4'(DIGIT_COUNT + 1) - 4'(step_ff);
      shown      = kind_ff || (step_ff == STEP_W'(1)) || (rest_ff != '0);
      digit_data = shown ? {4'd0, rem_wide[3:0]} : BLANK_CODE;
      if (position == 4'd2 && point_hi_ff) begin
         digit_data = digit_data | POINT_BIT;
      end else if (position == 4'd1 && point_lo_ff) begin
         digit_data = digit_data | POINT_BIT;
      end
   end

   // sequencer next state: idle loads an item and sends the scan limit; busy sends the next digit write
   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      rest_in      = rest_ff;
      kind_in      = kind_ff;
      point_hi_in  = point_hi_ff;
      point_lo_in  = point_lo_ff;
      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b0;
         if (busy_ff) begin
            out_valid_in = 1'b1;
            out_addr_in  = position;
            out_data_in  = digit_data;
            out_last_in  = (step_ff == STEP_W'(DIGIT_COUNT));
            rest_in      = quot;
            step_in      = step_ff + 1'b1;
            busy_in      = (step_ff != STEP_W'(DIGIT_COUNT));
         end else if (head.valid) begin
            out_valid_in = 1'b1;
            out_addr_in  = SCAN_LIMIT_ADDR;
            out_data_in  = 8'(DIGIT_COUNT - 1);
            out_last_in  = 1'b0;
            rest_in      = head.entry.value;
            kind_in      = head.entry.kind;
            point_hi_in  = head.entry.point_hi;
            point_lo_in  = head.entry.point_lo;
            step_in      = STEP_W'(1);
            busy_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rest_ff     <= rest_in;
      kind_ff     <= kind_in;
      point_hi_ff <= point_hi_in;
      point_lo_ff <= point_lo_in;
      out_addr_ff <= out_addr_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.reg_addr = out_addr_ff;
   assign rsp_chan.reg_data = out_data_ff;
   assign rsp_chan.last     = out_last_ff;

   `DDF_ASSERT_NOW(a_back_last_idle, clock, reset, out_valid_ff && out_last_ff, !busy_ff, "final write shown while still sequencing")
   `DDF_ASSERT_NOW(a_back_step_range, clock, reset, busy_ff, step_ff != '0 && step_ff <= STEP_W'(DIGIT_COUNT), "digit step out of range")
   `DDF_ASSERT_NEXT(a_back_pop_scan, clock, reset, pop, out_valid_ff && out_addr_ff == SCAN_LIMIT_ADDR && busy_ff, "item taken without scan limit write")

endmodule

### sim/decimal_display_formatter_top_tb.sv
// ---------------------------------------------------------------------------
// decimal_display_formatter_top_tb
// Self-checking bench for the decimal display formatter. Requests go in
// through the valid/ready request channel, register writes come back on the
// result channel and are compared field by field against writes predicted
// from each accepted request. Both channels idle in random bursts, and the
// final stretch runs at full rate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_display_formatter_top_tb;
   import ddf_pkg::*;

   localparam int DIGITS       = 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 230;
   localparam int CALM_ITEMS   = 40;

   // request kinds and the point type that marks position 1
   localparam logic       KIND_BLANK     = 1'b0;
   localparam logic       KIND_POINT     = 1'b1;
   localparam logic [7:0] POINT_TYPE_LOW = 8'd1;

   typedef struct packed {
      logic [3:0] reg_addr;
      logic [7:0] reg_data;
      logic       last;
   } reg_write_type;

   // expected register writes, oldest first
   class display_write_tracker;
      reg_write_type expected_writes[$];
      int unsigned   mismatches;

      function new();
         mismatches = 0;
      endfunction

      // predict the writes one request causes
      function void note_request(logic kind, logic [15:0] value,
                                 logic signed [7:0] point_value, logic [7:0] point_type);
         int unsigned   digit_count;
         int unsigned   scan;
         int unsigned   rest;
         int unsigned   pos;
         logic [7:0]    data;
         reg_write_type w;
         digit_count = 1;
         scan        = value;
         while (scan >= 10) begin
            scan = scan / 10;
            digit_count++;
         end
         w.reg_addr = SCAN_LIMIT_ADDR;
         w.reg_data = 8'(DIGITS - 1);
         w.last     = 1'b0;
         expected_writes.push_back(w);
         rest = value;
         for (int i = 1; i <= DIGITS; i++) begin
            pos  = DIGITS + 1 - i;
            data = 8'(rest % 10);
            if (kind == KIND_BLANK) begin
               if (i > digit_count) data = BLANK_CODE;
            end else if (pos == 2 && point_value > 0) begin
               data = data | POINT_BIT;
            end else if (pos == 1 && point_type == POINT_TYPE_LOW) begin
               data = data | POINT_BIT;
            end
            w.reg_addr = 4'(pos);
            w.reg_data = data;
            w.last     = (i == DIGITS);
            expected_writes.push_back(w);
            rest = rest / 10;
         end
      endfunction

      // compare one accepted write with the oldest prediction
      function void check_write(reg_write_type got);
         reg_write_type want;
         if (expected_writes.size() == 0) begin
            $error("unexpected write: reg_addr %0d reg_data 0x%02h last %0d",
                   got.reg_addr, got.reg_data, got.last);
            mismatches++;
            return;
         end
         want = expected_writes.pop_front();
         if (got.reg_addr !== want.reg_addr) begin
            $error("reg_addr: expected %0d, actual %0d", want.reg_addr, got.reg_addr);
            mismatches++;
         end
         if (got.reg_data !== want.reg_data) begin
            $error("reg_data: expected 0x%02h, actual 0x%02h", want.reg_data, got.reg_data);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return expected_writes.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic calm;
   int unsigned cycle_count;
   display_write_tracker tracker;

   ddf_req_if req_bus ();
   ddf_rsp_if rsp_bus ();

   decimal_display_formatter_top #(
      .DIGIT_COUNT (DIGITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // optional idle burst, then one request held until taken
   task automatic send_request(logic kind, logic [15:0] value,
                               logic signed [7:0] point_value, logic [7:0] point_type);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid       <= 1'b0;
         req_bus.value       <= 16'($urandom);
         req_bus.point_value <= 8'($urandom);
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= kind;
      req_bus.value       <= value;
      req_bus.point_value <= point_value;
      req_bus.point_type  <= point_type;
      do @(negedge clock); while (!req_bus.ready);
      tracker.note_request(kind, value, point_value, point_type);
      @(posedge clock);
   endtask

   // result side back-pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // result monitor, sampled away from the active edge
   always @(negedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         tracker.check_write('{rsp_bus.reg_addr, rsp_bus.reg_data, rsp_bus.last});
   end

   // stimulus
   initial begin
      logic [15:0] edge_values [10];
      logic        kind;
      logic [15:0] value;
      logic [7:0]  point_type;
      edge_values = '{16'd0, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999,
                      16'd1000, 16'd9999, 16'd10000, 16'd65535};
      tracker              = new();
      calm                 = 1'b0;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= KIND_BLANK;
      req_bus.value       <= '0;
      req_bus.point_value <= '0;
      req_bus.point_type  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // blanked mode across digit-count boundaries, zero and oversize values
      send_request(KIND_BLANK, 16'd0, 8'sd0, 8'd0);
      send_request(KIND_BLANK, 16'd9, 8'sd0, 8'd0);
      send_request(KIND_BLANK, 16'd10, 8'sd0, 8'd0);
      send_request(KIND_BLANK, 16'd99, 8'sd0, 8'd0);
      send_request(KIND_BLANK, 16'd100, 8'sd0, 8'd0);
      send_request(KIND_BLANK, 16'd999, 8'sd0, 8'd0);
      send_request(KIND_BLANK, 16'd1000, 8'sd0, 8'd0);
      send_request(KIND_BLANK, 16'd9999, 8'sd0, 8'd0);
      send_request(KIND_BLANK, 16'd10000, 8'sd0, 8'd0);
      send_request(KIND_BLANK, 16'd65535, 8'sd0, 8'd0);
      // point inputs must be ignored in blanked mode
      send_request(KIND_BLANK, 16'd12, 8'sd127, POINT_TYPE_LOW);
      send_request(KIND_BLANK, 16'd5, 8'sd1, 8'd255);

      // point mode: leading zeros shown, point marks on either position
      send_request(KIND_POINT, 16'd0, 8'sd0, 8'd0);
      send_request(KIND_POINT, 16'd65535, 8'sd127, 8'd255);
      send_request(KIND_POINT, 16'd1234, 8'sd1, POINT_TYPE_LOW);
      send_request(KIND_POINT, 16'd1234, -8'sd1, POINT_TYPE_LOW);
      send_request(KIND_POINT, 16'd1234, -8'sd128, 8'd0);
      send_request(KIND_POINT, 16'd5678, 8'sd0, POINT_TYPE_LOW);
      send_request(KIND_POINT, 16'd10000, 8'sd2, 8'd2);
      send_request(KIND_POINT, 16'd9999, 8'sd127, POINT_TYPE_LOW);
      send_request(KIND_POINT, 16'd42, -8'sd128, 8'd255);
      send_request(KIND_POINT, 16'd7, 8'sd1, 8'd0);
      send_request(KIND_POINT, 16'd99, 8'sd0, 8'd0);

      // random requests
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // hold off once until the block has drained
         if (n == RANDOM_ITEMS / 2 && tracker.pending() != 0) begin
            req_bus.valid <= 1'b0;
            while (tracker.pending() != 0) @(posedge clock);
         end
         calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
         kind = 1'($urandom);
         case ($urandom_range(0, 5))
            0: value = 16'($urandom_range(0, 9));
            1: value = 16'($urandom_range(0, 99));
            2: value = 16'($urandom_range(0, 999));
            3: value = 16'($urandom_range(0, 9999));
            4: value = edge_values[$urandom_range(0, 9)];
            default: value = 16'($urandom);
         endcase
         point_type = ($urandom_range(0, 2) == 0) ? POINT_TYPE_LOW : 8'($urandom);
         send_request(kind, value, 8'($urandom), point_type);
      end

      // drain and let the tail settle
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DIGITS + 4) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ddf_pkg.sv
hw/rtl/ddf_channels.sv
hw/rtl/ddf_front.sv
hw/rtl/ddf_queue.sv
hw/rtl/ddf_back.sv
hw/rtl/decimal_display_formatter_top.sv
sim/decimal_display_formatter_top_tb.sv
